// File: design/ssvf_pkg.sv
package ssvf_pkg;

	localparam logic [2:0] KIND_INT   = 3'd0;
	localparam logic [2:0] KIND_TEMP  = 3'd1;
	localparam logic [2:0] KIND_TIME  = 3'd2;
	localparam logic [2:0] KIND_SYM   = 3'd3;
	localparam logic [2:0] KIND_COLON = 3'd4;

	localparam logic [6:0] SEG_BLANK  = 7'h00;
	localparam logic [6:0] SEG_MINUS  = 7'h40;
	localparam logic [6:0] SEG_UNDER  = 7'h08;
	localparam logic [6:0] SEG_TOP    = 7'h01;
	localparam logic [6:0] SEG_DEGREE = 7'h63;
	localparam logic [6:0] SEG_C_UP   = 7'h39;
	localparam logic [6:0] SEG_C_HIGH = 7'h61;
	localparam logic [6:0] SEG_U      = 7'h3e;

	localparam logic [7:0] SEG_POINT  = 8'h80;
	localparam logic [6:0] CODE_BLANK = 7'h7f;

	localparam logic signed [15:0] INT_MAX  = 16'sd9999;
	localparam logic signed [15:0] INT_MIN  = -16'sd999;
	localparam logic signed [15:0] TEMP_LOW = -16'sd99;
	localparam logic signed [15:0] TEMP_NEG = -16'sd9;
	localparam logic signed [15:0] TEMP_TOP = 16'sd999;
	localparam logic signed [15:0] TEMP_MID = 16'sd99;
	localparam logic signed [15:0] TIME_MAX = 16'sd1440;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [15:0] value;
		logic [7:0]         symbol;
		logic               colon_on;
	} ssvf_req_t;

	typedef struct packed {
		logic [7:0] seg_digit0;
		logic [7:0] seg_digit1;
		logic [7:0] seg_digit2;
		logic [7:0] seg_digit3;
	} ssvf_rsp_t;

	function automatic logic [6:0] hex_seg(input logic [3:0] d);
		logic [6:0] s;
		case (d)
			4'h0: s = 7'h3f;
			4'h1: s = 7'h06;
			4'h2: s = 7'h5b;
			4'h3: s = 7'h4f;
			4'h4: s = 7'h66;
			4'h5: s = 7'h6d;
			4'h6: s = 7'h7d;
			4'h7: s = 7'h07;
			4'h8: s = 7'h7f;
			4'h9: s = 7'h6f;
			4'ha: s = 7'h77;
			4'hb: s = 7'h7c;
			4'hc: s = 7'h39;
			4'hd: s = 7'h5e;
			4'he: s = 7'h79;
			default: s = 7'h71;
		endcase
		return s;
	endfunction

	function automatic logic [6:0] sym_seg(input logic [6:0] c);
		logic [6:0] s;
		if (c == CODE_BLANK) begin
			s = SEG_BLANK;
		end else if (c < 7'h10) begin
			s = hex_seg(c[3:0]);
		end else if (c >= 7'h30 && c <= 7'h39) begin
			s = hex_seg(4'(c - 7'h30));
		end else begin
			case (c)
				7'h41: s = 7'h77;
				7'h62: s = 7'h7c;
				7'h43: s = SEG_C_UP;
				7'h64: s = 7'h5e;
				7'h45: s = 7'h79;
				7'h46: s = 7'h71;
				7'h5f: s = SEG_UNDER;
				7'h5e: s = SEG_TOP;
				7'h2d: s = SEG_MINUS;
				7'h2a: s = SEG_DEGREE;
				7'h63: s = SEG_C_HIGH;
				7'h55: s = SEG_U;
				default: s = SEG_BLANK;
			endcase
		end
		return s;
	endfunction

	// Quotients by reciprocal multiplication, exact for inputs up to 9999.
	function automatic logic [10:0] div10(input logic [13:0] a);
		logic [29:0] p;
		p = 30'(a) * 30'd52429;
		return p[29:19];
	endfunction

	function automatic logic [6:0] div100(input logic [13:0] a);
		logic [27:0] p;
		p = 28'(a) * 28'd5243;
		return p[25:19];
	endfunction

	function automatic logic [3:0] div1000(input logic [13:0] a);
		logic [27:0] p;
		p = 28'(a) * 28'd8389;
		return p[26:23];
	endfunction

	// Tens and units of a value below 64, by comparison.
	function automatic logic [7:0] split_tens(input logic [5:0] x);
		logic [3:0] t;
		if (x >= 6'd60) begin
			t = 4'd6;
		end else if (x >= 6'd50) begin
			t = 4'd5;
		end else if (x >= 6'd40) begin
			t = 4'd4;
		end else if (x >= 6'd30) begin
			t = 4'd3;
		end else if (x >= 6'd20) begin
			t = 4'd2;
		end else if (x >= 6'd10) begin
			t = 4'd1;
		end else begin
			t = 4'd0;
		end
		return {t, 4'(x - 6'(t) * 6'd10)};
	endfunction

endpackage

// File: design/seven_segment_value_formatter_unit.sv
// Path: a request beat is taken into the input register, and its result beat is offered from the result register.
// Throughput: one request beat per cycle; the input register and the result
// register each hold one beat, so stall back-pressure reaches the input after both fill.
// Reset: arst_n clears the valid flags and the colon flag (colon off) at once.
module seven_segment_value_formatter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ssvf_pkg::ssvf_req_t req_data,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ssvf_pkg::ssvf_rsp_t rsp_data
);
	import ssvf_pkg::*;

	ssvf_req_t          req_s1;
	logic               valid_s1;
	logic               rsp_valid_q;
	ssvf_rsp_t          rsp_data_q;
	logic               colon_q;

	logic               adv;
	logic signed [15:0] v;
	logic [15:0]        vu;
	logic [15:0]        mag;
	logic [13:0]        a;
	logic [10:0]        q10;
	logic [6:0]         q100;
	logic [3:0]         d0, d1, d2, d3;
	logic [10:0]        tv;
	logic [21:0]        hp;
	logic [4:0]         hours;
	logic [5:0]         mins;
	logic [7:0]         hsplit, msplit;
	logic [6:0]         s0, s1, s2, s3;
	logic               pt3;
	logic               has_rsp;
	logic               colon_nxt;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !adv;

	assign v    = req_s1.value;
	assign vu   = req_s1.value;
	assign mag  = v[15] ? (16'd0 - vu) : vu;
	assign a    = mag[13:0];
	assign q10  = div10(a);
	assign q100 = div100(a);
	assign d0   = div1000(a);
	assign d3   = 4'(a - 14'(q10) * 14'd10);
	assign d2   = 4'(q10 - 11'(q100) * 11'd10);
	assign d1   = 4'(q100 - 7'(d0) * 7'd10);

	assign tv     = vu[10:0];
	assign hp     = 22'(tv) * 22'd1093;
	assign hours  = hp[20:16];
	assign mins   = 6'(tv - 11'(hours) * 11'd60);
	assign hsplit = split_tens(6'(hours));
	assign msplit = split_tens(mins);

	always_comb begin
		s0        = SEG_BLANK;
		s1        = SEG_BLANK;
		s2        = SEG_BLANK;
		s3        = SEG_BLANK;
		pt3       = 1'b0;
		has_rsp   = 1'b0;
		colon_nxt = colon_q;
		case (req_s1.kind)
			KIND_INT: begin
				has_rsp = (v <= INT_MAX) && (v >= INT_MIN);
				s3 = hex_seg(d3);
				if (v[15]) begin
					if (d1 != 4'd0) begin
						s0 = SEG_MINUS;
						s1 = hex_seg(d1);
						s2 = hex_seg(d2);
					end else if (d2 != 4'd0) begin
						s1 = SEG_MINUS;
						s2 = hex_seg(d2);
					end else begin
						s2 = SEG_MINUS;
					end
				end else begin
					if (d0 != 4'd0) begin
						s0 = hex_seg(d0);
					end
					if (d0 != 4'd0 || d1 != 4'd0) begin
						s1 = hex_seg(d1);
					end
					if (d0 != 4'd0 || d1 != 4'd0 || d2 != 4'd0) begin
						s2 = hex_seg(d2);
					end
				end
			end
			KIND_TEMP: begin
				has_rsp   = 1'b1;
				colon_nxt = 1'b0;
				if (v < TEMP_LOW) begin
					s0 = SEG_UNDER;
					s1 = SEG_UNDER;
					s2 = SEG_UNDER;
					s3 = SEG_DEGREE;
				end else if (v < TEMP_NEG) begin
					s0 = SEG_MINUS;
					s1 = hex_seg(d2);
					s2 = hex_seg(d3);
					s3 = SEG_DEGREE;
				end else if (v[15]) begin
					s0 = SEG_MINUS;
					s1 = hex_seg(d3);
					s2 = SEG_DEGREE;
					s3 = SEG_C_UP;
				end else if (v > TEMP_TOP) begin
					s0 = SEG_TOP;
					s1 = SEG_TOP;
					s2 = SEG_TOP;
					s3 = SEG_DEGREE;
				end else if (v > TEMP_MID) begin
					s0 = hex_seg(d1);
					s1 = hex_seg(d2);
					s2 = hex_seg(d3);
					s3 = SEG_DEGREE;
				end else begin
					if (d2 != 4'd0) begin
						s0 = hex_seg(d2);
					end
					s1 = hex_seg(d3);
					s2 = SEG_DEGREE;
					s3 = SEG_C_UP;
				end
			end
			KIND_TIME: begin
				has_rsp = !v[15] && (v <= TIME_MAX);
				s0 = hex_seg(hsplit[7:4]);
				s1 = hex_seg(hsplit[3:0]);
				s2 = hex_seg(msplit[7:4]);
				s3 = hex_seg(msplit[3:0]);
			end
			KIND_SYM: begin
				has_rsp   = (v <= TEMP_TOP) && (v >= TEMP_LOW);
				colon_nxt = 1'b0;
				if (v[15]) begin
					s0 = SEG_MINUS;
					s1 = hex_seg(d2);
					s2 = hex_seg(d3);
				end else begin
					s0 = hex_seg(d1);
					s1 = hex_seg(d2);
					s2 = hex_seg(d3);
				end
				s3  = sym_seg(req_s1.symbol[6:0]);
				pt3 = req_s1.symbol[7];
			end
			KIND_COLON: begin
				colon_nxt = req_s1.colon_on;
			end
			default: begin
				has_rsp = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			colon_q     <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid_q <= valid_s1 && has_rsp;
				if (valid_s1) begin
					colon_q <= colon_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_data;
		end
		if (adv && valid_s1 && has_rsp) begin
			rsp_data_q.seg_digit0 <= {colon_nxt, s0};
			rsp_data_q.seg_digit1 <= {colon_nxt, s1};
			rsp_data_q.seg_digit2 <= {colon_nxt, s2};
			rsp_data_q.seg_digit3 <= {colon_nxt, s3} | (pt3 ? SEG_POINT : 8'h00);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

`ifndef NO_ASSERTIONS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && rsp_valid_q && rsp_stall))
		else $error("input stalled without a held result");

	a_colon_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s1 && (req_s1.kind == KIND_TEMP || req_s1.kind == KIND_SYM))
		|=> !colon_q)
		else $error("colon flag not cleared");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(valid_s1))
		else $error("result without a request in the input register");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import ssvf_pkg::*;

	class display_scoreboard;
		localparam logic [7:0] CH_BLANK   = 8'h20;
		localparam logic [7:0] CH_MINUS   = 8'h2d;
		localparam logic [7:0] CH_UNDER   = 8'h5f;
		localparam logic [7:0] CH_TOP     = 8'h5e;
		localparam logic [7:0] CH_DEGREE  = 8'h2a;
		localparam logic [7:0] CH_CELSIUS = 8'h43;
		localparam logic [6:0] CH_VOID    = 7'h7f;

		bit          colon;
		ssvf_rsp_t   due_displays[$];
		int unsigned shown_count;
		int unsigned errors;

		task report(input string what);
			errors++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		function logic [6:0] digit_pattern(input logic [3:0] n);
			logic [6:0] p;
			case (n)
				4'h0: p = 7'h3f;
				4'h1: p = 7'h06;
				4'h2: p = 7'h5b;
				4'h3: p = 7'h4f;
				4'h4: p = 7'h66;
				4'h5: p = 7'h6d;
				4'h6: p = 7'h7d;
				4'h7: p = 7'h07;
				4'h8: p = 7'h7f;
				4'h9: p = 7'h6f;
				4'ha: p = 7'h77;
				4'hb: p = 7'h7c;
				4'hc: p = 7'h39;
				4'hd: p = 7'h5e;
				4'he: p = 7'h79;
				default: p = 7'h71;
			endcase
			return p;
		endfunction

		function logic [7:0] segments(input logic [7:0] code);
			logic [6:0] c;
			logic [7:0] s;
			c = code[6:0];
			if (c == CH_VOID) begin
				s = 8'h00;
			end else if (c < 7'h10) begin
				s = {1'b0, digit_pattern(c[3:0])};
			end else if (c >= 7'h30 && c <= 7'h39) begin
				s = {1'b0, digit_pattern(4'(c - 7'h30))};
			end else begin
				case (c)
					7'h41: s = 8'h77;
					7'h62: s = 8'h7c;
					7'h43: s = 8'h39;
					7'h64: s = 8'h5e;
					7'h45: s = 8'h79;
					7'h46: s = 8'h71;
					7'h5f: s = 8'h08;
					7'h5e: s = 8'h01;
					7'h2d: s = 8'h40;
					7'h2a: s = 8'h63;
					7'h63: s = 8'h61;
					7'h55: s = 8'h3e;
					default: s = 8'h00;
				endcase
			end
			if (code[7] || colon) begin
				s[7] = 1'b1;
			end
			return s;
		endfunction

		function void predict_display(input ssvf_req_t r);
			int         v;
			int         a;
			int         h;
			int         m;
			bit         shown;
			bit         lead;
			logic [7:0] d [4];
			v = int'($signed(r.value));
			shown = 1'b1;
			case (r.kind)
				KIND_INT: begin
					if (v > 9999 || v < -999) begin
						shown = 1'b0;
					end else begin
						a = (v < 0) ? -v : v;
						d[0] = 8'(a / 1000);
						d[1] = 8'((a / 100) % 10);
						d[2] = 8'((a / 10) % 10);
						d[3] = 8'(a % 10);
						lead = 1'b1;
						for (int i = 0; i < 3; i++) begin
							if (lead && d[i] == 8'd0) begin
								if (v >= 0 || d[i + 1] == 8'd0) begin
									d[i] = CH_BLANK;
								end else begin
									d[i] = CH_MINUS;
									lead = 1'b0;
								end
							end else begin
								lead = 1'b0;
							end
						end
					end
				end
				KIND_TEMP: begin
					colon = 1'b0;
					if (v < -99) begin
						d = '{CH_UNDER, CH_UNDER, CH_UNDER, CH_DEGREE};
					end else if (v < -9) begin
						d = '{CH_MINUS, 8'((-v) / 10), 8'((-v) % 10), CH_DEGREE};
					end else if (v < 0) begin
						d = '{CH_MINUS, 8'(-v), CH_DEGREE, CH_CELSIUS};
					end else if (v > 999) begin
						d = '{CH_TOP, CH_TOP, CH_TOP, CH_DEGREE};
					end else if (v > 99) begin
						d = '{8'(v / 100), 8'((v / 10) % 10), 8'(v % 10), CH_DEGREE};
					end else begin
						d = '{(v < 10) ? CH_BLANK : 8'(v / 10), 8'(v % 10), CH_DEGREE,
							CH_CELSIUS};
					end
				end
				KIND_TIME: begin
					if (v < 0 || v > 1440) begin
						shown = 1'b0;
					end else begin
						h = v / 60;
						m = v % 60;
						d = '{8'(h / 10), 8'(h % 10), 8'(m / 10), 8'(m % 10)};
					end
				end
				KIND_SYM: begin
					colon = 1'b0;
					if (v > 999 || v < -99) begin
						shown = 1'b0;
					end else if (v < 0) begin
						d = '{CH_MINUS, 8'((-v) / 10), 8'((-v) % 10), r.symbol};
					end else begin
						d = '{8'(v / 100), 8'((v / 10) % 10), 8'(v % 10), r.symbol};
					end
				end
				KIND_COLON: begin
					colon = r.colon_on;
					shown = 1'b0;
				end
				default: begin
					shown = 1'b0;
				end
			endcase
			if (shown) begin
				due_displays.push_back({segments(d[0]), segments(d[1]), segments(d[2]),
					segments(d[3])});
			end
		endfunction

		task check_display(input ssvf_rsp_t got);
			ssvf_rsp_t want;
			bit        ok;
			if (due_displays.size() == 0) begin
				report($sformatf("result beat %h with none outstanding", got));
				return;
			end
			want = due_displays.pop_front();
			ok = 1'b1;
			for (int i = 0; i < 4; i++) begin
				if (got[31 - 8 * i -: 8] !== want[31 - 8 * i -: 8]) begin
					report($sformatf("seg_digit%0d got %h want %h", i, got[31 - 8 * i -: 8],
						want[31 - 8 * i -: 8]));
					ok = 1'b0;
				end
			end
			if (ok) begin
				shown_count++;
			end
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	ssvf_req_t req_data;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	ssvf_rsp_t rsp_data;

	display_scoreboard sb;
	int unsigned       idle_pct;
	int unsigned       stall_pct;
	int unsigned       sent_count;

	int         bound_values [21] = '{-32768, -1000, -999, -100, -99, -10, -9, -1, 0, 1, 9,
		10, 99, 100, 999, 1000, 1440, 1441, 9999, 10000, 32767};
	logic [6:0] glyph_codes [14] = '{7'h41, 7'h62, 7'h43, 7'h64, 7'h45, 7'h46, 7'h5f, 7'h5e,
		7'h2d, 7'h2a, 7'h20, 7'h63, 7'h55, 7'h7f};

	seven_segment_value_formatter_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				sb.check_display(rsp_data);
			end
			if (req_valid && !req_stall) begin
				sb.predict_display(req_data);
			end
		end
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	function automatic ssvf_req_t random_request();
		ssvf_req_t  r;
		int         v;
		logic [6:0] c;
		if ($urandom_range(0, 99) < 6) begin
			r.kind = 3'($urandom_range(int'(KIND_COLON) + 1, 7));
		end else begin
			r.kind = 3'($urandom_range(int'(KIND_INT), int'(KIND_COLON)));
		end
		case ($urandom_range(0, 9))
			0: v = int'($urandom);
			1: v = bound_values[$urandom_range(0, 20)];
			default: begin
				case (r.kind)
					KIND_INT:  v = int'($urandom_range(0, 10998)) - 999;
					KIND_TEMP: v = int'($urandom_range(0, 1140)) - 120;
					KIND_TIME: v = int'($urandom_range(0, 1440));
					KIND_SYM:  v = int'($urandom_range(0, 1098)) - 99;
					default:   v = int'($urandom);
				endcase
			end
		endcase
		r.value = 16'(v);
		case ($urandom_range(0, 3))
			0: c = 7'($urandom_range(0, 15));
			1: c = 7'($urandom_range(7'h30, 7'h39));
			2: c = glyph_codes[$urandom_range(0, 13)];
			default: c = 7'($urandom);
		endcase
		r.symbol = {1'($urandom), c};
		r.colon_on = 1'($urandom);
		return r;
	endfunction

	task automatic send_request(input ssvf_req_t r);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			req_data <= random_request();
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (req_stall);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [2:0] kind, input int value,
		input logic [7:0] symbol, input logic colon_on);
		ssvf_req_t r;
		r.kind = kind;
		r.value = 16'(value);
		r.symbol = symbol;
		r.colon_on = colon_on;
		send_request(r);
	endtask

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		sent_count = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_fields(KIND_INT, 0, 8'h00, 1'b0);
		send_fields(KIND_INT, 9999, 8'hff, 1'b1);
		send_fields(KIND_INT, 10000, 8'h00, 1'b0);
		send_fields(KIND_INT, -999, 8'h00, 1'b0);
		send_fields(KIND_INT, -1000, 8'h00, 1'b0);
		send_fields(KIND_INT, -5, 8'h00, 1'b0);
		send_fields(KIND_INT, -100, 8'h00, 1'b0);
		send_fields(KIND_INT, -32768, 8'h00, 1'b0);
		send_fields(KIND_INT, 32767, 8'h00, 1'b0);
		send_fields(KIND_COLON, 0, 8'h00, 1'b1);
		send_fields(KIND_INT, 1208, 8'h00, 1'b0);
		send_fields(KIND_TIME, 0, 8'h00, 1'b0);
		send_fields(KIND_TIME, 1440, 8'h00, 1'b0);
		send_fields(KIND_TIME, 1441, 8'h00, 1'b0);
		send_fields(KIND_TIME, -1, 8'h00, 1'b0);
		send_fields(KIND_TEMP, -100, 8'h00, 1'b0);
		send_fields(KIND_TEMP, -10, 8'h00, 1'b0);
		send_fields(KIND_TEMP, -9, 8'h00, 1'b0);
		send_fields(KIND_TEMP, 7, 8'h00, 1'b0);
		send_fields(KIND_TEMP, 99, 8'h00, 1'b0);
		send_fields(KIND_TEMP, 100, 8'h00, 1'b0);
		send_fields(KIND_TEMP, 1000, 8'h00, 1'b0);
		send_fields(KIND_SYM, 999, 8'h7f, 1'b0);
		send_fields(KIND_SYM, -99, 8'haa, 1'b0);
		send_fields(KIND_COLON, 0, 8'h00, 1'b1);
		send_fields(KIND_SYM, 1000, 8'h00, 1'b0);
		send_fields(KIND_INT, 5, 8'h00, 1'b0);
		send_fields(3'h5, 12, 8'h00, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 54; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 54; end
				default: begin idle_pct = 14; stall_pct = 14; end
			endcase
			repeat (355) send_request(random_request());
			if (phase == 1) begin
				req_valid <= 1'b0;
				do @(negedge clk); while (sb.due_displays.size() != 0);
			end
		end

		req_valid <= 1'b0;
		while (sb.due_displays.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("Sent %0d request beats over four pacing phases; %0d display beats matched.",
			sent_count, sb.shown_count);
		$display("Kinds, range limits, sign and blanking, colon and symbol codes were exercised.");
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// File: files.f
design/ssvf_pkg.sv
design/seven_segment_value_formatter_unit.sv
tb/sv/tb.sv
